### hdl/trct_pkg.sv
// Shared types and codes for the transport receiver connection table.
package trct_pkg;

    typedef enum logic [2:0] {
        ACT_SEGMENT = 3'd0,
        ACT_OPEN    = 3'd1,
        ACT_LISTEN  = 3'd2,
        ACT_CONSUME = 3'd3,
        ACT_CLOSE   = 3'd4
    } t_action;

    localparam logic [2:0] SEG_SYN     = 3'd0;
    localparam logic [2:0] SEG_SYNACK  = 3'd1;
    localparam logic [2:0] SEG_FIN     = 3'd2;
    localparam logic [2:0] SEG_FINACK  = 3'd3;
    localparam logic [2:0] SEG_DATA    = 3'd4;
    localparam logic [2:0] SEG_DATAACK = 3'd5;
    localparam logic [2:0] SEG_NONE    = 3'd0;

    localparam logic [1:0] MODE_CLOSED = 2'd0;
    localparam logic [1:0] MODE_LISTEN = 2'd1;
    localparam logic [1:0] MODE_CONN   = 2'd2;
    localparam logic [1:0] MODE_CWAIT  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN_REQ,
        FSM_SCAN_CHK,
        FSM_RD_REQ,
        FSM_RD_WAIT,
        FSM_EXEC,
        FSM_DONE
    } t_fsm;

endpackage

### hdl/trct_ram.sv
// Generic single-port RAM with registered read.
module trct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                             i_wdata,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write, and read the old contents registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/transport_receiver_connection_table.sv
// Top level of the transport receiver connection table.
// One command is taken when start is high and busy is low; exactly one
// result then appears for one cycle on o_done and cannot be held off. A
// segment walks the slot table one slot at a time (RAM read, then compare)
// until a matching slot or the end of the table; opening a slot walks the
// in-use flags one per cycle; listen, consume and close do one entry read,
// modify and write back. All slot fields live in one RAM; in-use flags are
// flip-flops cleared by reset.
module transport_receiver_connection_table #(
    parameter int SLOTS        = 8,
    parameter int BUFFER_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    output logic        o_done,
    input  logic [2:0]  i_action,
    input  logic [2:0]  i_seg_type,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_seq_num,
    input  logic [15:0] i_data_length,
    input  logic [15:0] i_open_port,
    input  logic [2:0]  i_slot,
    input  logic [16:0] i_read_length,
    output logic        o_send_valid,
    output logic [2:0]  o_reply_type,
    output logic [15:0] o_reply_src_port,
    output logic [15:0] o_reply_dst_port,
    output logic [31:0] o_reply_ack,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_out,
    output logic [1:0]  o_conn_state,
    output logic [16:0] o_buffered_bytes
);
    import trct_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = ($clog2(BUFFER_BYTES) + 1 > 17) ? $clog2(BUFFER_BYTES) + 1 : 17;
    localparam int EW = 2 + 16 + 16 + 32 + FW;
    localparam logic [FW:0] BUF_LIM = (FW+1)'(BUFFER_BYTES);
    localparam logic [AW:0] LAST = (AW+1)'(SLOTS - 1);

    t_fsm r_state, n_state;
    logic [SLOTS-1:0] r_use;
    logic [AW:0] r_idx;
    logic [2:0]  r_act, r_typ, r_slot;
    logic [15:0] r_src, r_dst, r_len, r_oport;
    logic [31:0] r_seq;
    logic [16:0] r_rlen;

    logic           we;
    logic [AW-1:0]  addr;
    logic [EW-1:0]  wdata, rdata;

    logic        r_sv;
    logic [2:0]  r_rt;
    logic [15:0] r_rs, r_rd;
    logic [31:0] r_ra;
    logic [1:0]  r_st;
    logic [2:0]  r_so;
    logic [1:0]  r_cs;
    logic [16:0] r_bb;

    // fields of the entry read
    logic [1:0]    e_mode;
    logic [15:0]   e_lp, e_pp;
    logic [31:0]   e_seq;
    logic [FW-1:0] e_fill;
    assign {e_mode, e_lp, e_pp, e_seq, e_fill} = rdata;

    trct_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    logic slot_ok;
    assign slot_ok = (32'(r_slot) < 32'(SLOTS)) && r_use[AW'(r_slot)];

    logic [FW:0] sum_fill;
    assign sum_fill = {1'b0, e_fill} + (FW+1)'(r_len);

    // state register, in-use flags, command capture and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_use   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FSM_EXEC) begin
                if (r_act == ACT_OPEN && r_idx <= LAST) begin
                    r_use[r_idx[AW-1:0]] <= 1'b1;
                end
                if (r_act == ACT_CLOSE && slot_ok &&
                    (e_mode == MODE_CWAIT || e_mode == MODE_CLOSED)) begin
                    r_use[AW'(r_slot)] <= 1'b0;
                end
            end
        end
        if (r_state == FSM_IDLE && start) begin
            r_act <= i_action; r_typ <= i_seg_type; r_src <= i_src_port;
            r_dst <= i_dst_port; r_seq <= i_seq_num; r_len <= i_data_length;
            r_oport <= i_open_port; r_slot <= i_slot; r_rlen <= i_read_length;
        end
        if (r_state == FSM_IDLE) begin
            r_idx <= '0;
        end else if (r_state == FSM_SCAN_CHK && n_state == FSM_SCAN_REQ) begin
            r_idx <= r_idx + 1'b1;
        end else if (r_state == FSM_SCAN_REQ && r_act == ACT_OPEN) begin
            // open walks the flags without a RAM read
            if (r_use[r_idx[AW-1:0]] && r_idx < LAST + 1'b1) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // next state, RAM access and result
    always_comb begin
        n_state = r_state;
        we = 1'b0;
        addr = r_idx[AW-1:0];
        wdata = rdata;
        busy = (r_state != FSM_IDLE);
        o_done = (r_state == FSM_DONE);
        unique case (r_state)
            FSM_IDLE: if (start) begin
                n_state = (i_action == ACT_SEGMENT || i_action == ACT_OPEN) ?
                          FSM_SCAN_REQ : FSM_RD_REQ;
            end
            FSM_SCAN_REQ: begin
                if (r_act == ACT_OPEN) begin
                    if (r_idx > LAST || !r_use[r_idx[AW-1:0]]) n_state = FSM_EXEC;
                end else if (r_idx > LAST) begin
                    n_state = FSM_EXEC;
                end else begin
                    n_state = FSM_SCAN_CHK;
                end
            end
            FSM_SCAN_CHK: begin
                if (r_use[r_idx[AW-1:0]] && e_lp == r_dst) n_state = FSM_EXEC;
                else n_state = FSM_SCAN_REQ;
            end
            FSM_RD_REQ: begin
                addr = AW'(r_slot);
                n_state = FSM_RD_WAIT;
            end
            FSM_RD_WAIT: begin
                addr = AW'(r_slot);
                n_state = FSM_EXEC;
            end
            FSM_EXEC: begin
                n_state = FSM_DONE;
                addr = (r_act == ACT_SEGMENT || r_act == ACT_OPEN) ?
                       r_idx[AW-1:0] : AW'(r_slot);
                case (r_act)
                    ACT_SEGMENT: if (r_idx <= LAST) begin
                        we = 1'b1;
                        case (e_mode)
                            MODE_LISTEN: if (r_typ == SEG_SYN) begin
                                wdata = {MODE_CONN, e_lp, r_src, r_seq + 32'd1, e_fill};
                            end
                            MODE_CONN: begin
                                if (r_typ == SEG_SYN)
                                    wdata = {e_mode, e_lp, e_pp, r_seq + 32'd1, e_fill};
                                else if (r_typ == SEG_FIN)
                                    wdata = {MODE_CWAIT, e_lp, e_pp, e_seq, e_fill};
                                else if (r_typ == SEG_DATA && sum_fill <= BUF_LIM &&
                                         e_seq == r_seq)
                                    wdata = {e_mode, e_lp, e_pp, r_seq + 32'(r_len),
                                             sum_fill[FW-1:0]};
                            end
                            default: ;
                        endcase
                    end
                    ACT_OPEN: if (r_idx <= LAST) begin
                        we = 1'b1;
                        wdata = {MODE_CLOSED, r_oport, 16'd0, 32'd0, {FW{1'b0}}};
                    end
                    ACT_LISTEN: if (slot_ok) begin
                        we = 1'b1;
                        wdata = {MODE_LISTEN, e_lp, e_pp, e_seq, e_fill};
                    end
                    ACT_CONSUME: if (slot_ok && e_fill >= FW'(r_rlen)) begin
                        we = 1'b1;
                        wdata = {e_mode, e_lp, e_pp, e_seq, e_fill - FW'(r_rlen)};
                    end
                    ACT_CLOSE: if (slot_ok &&
                                   (e_mode == MODE_CWAIT || e_mode == MODE_CLOSED)) begin
                        we = 1'b1;
                        wdata = {MODE_CLOSED, e_lp, e_pp, e_seq, {FW{1'b0}}};
                    end
                    default: ;
                endcase
            end
            FSM_DONE: n_state = FSM_IDLE;
            default: n_state = FSM_IDLE;
        endcase
    end

    // build the result while the entry is modified
    always_ff @(posedge i_clk) begin
        if (r_state == FSM_EXEC) begin
            r_sv <= 1'b0; r_rt <= SEG_NONE; r_rs <= '0; r_rd <= '0; r_ra <= '0;
            r_st <= ST_FAIL; r_so <= '0; r_cs <= MODE_CLOSED; r_bb <= '0;
            case (r_act)
                ACT_SEGMENT: begin
                    r_st <= ST_DROPPED;
                    if (r_idx <= LAST) begin
                        r_so <= 3'(r_idx); r_cs <= e_mode; r_bb <= 17'(e_fill);
                        case (e_mode)
                            MODE_LISTEN: if (r_typ == SEG_SYN) begin
                                r_sv <= 1'b1; r_rt <= SEG_SYNACK; r_rs <= e_lp;
                                r_rd <= r_src; r_ra <= r_seq + 32'd1; r_st <= ST_OK;
                                r_cs <= MODE_CONN;
                            end
                            MODE_CONN: begin
                                if (r_typ == SEG_SYN) begin
                                    r_sv <= 1'b1; r_rt <= SEG_SYNACK; r_rs <= e_lp;
                                    r_rd <= e_pp; r_ra <= r_seq + 32'd1; r_st <= ST_OK;
                                end else if (r_typ == SEG_FIN) begin
                                    r_sv <= 1'b1; r_rt <= SEG_FINACK; r_rs <= e_lp;
                                    r_rd <= e_pp; r_st <= ST_OK; r_cs <= MODE_CWAIT;
                                end else if (r_typ == SEG_DATA && sum_fill <= BUF_LIM) begin
                                    r_sv <= 1'b1; r_rt <= SEG_DATAACK; r_rs <= e_lp;
                                    r_rd <= e_pp; r_st <= ST_OK;
                                    if (e_seq == r_seq) begin
                                        r_ra <= r_seq + 32'(r_len);
                                        r_bb <= 17'(sum_fill);
                                    end else begin
                                        r_ra <= e_seq;
                                    end
                                end
                            end
                            MODE_CWAIT: if (r_typ == SEG_FIN) begin
                                r_sv <= 1'b1; r_rt <= SEG_FINACK; r_rs <= e_lp;
                                r_rd <= e_pp; r_st <= ST_OK;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_OPEN: if (r_idx <= LAST) begin
                    r_st <= ST_OK; r_so <= 3'(r_idx);
                end
                ACT_LISTEN, ACT_CONSUME, ACT_CLOSE: begin
                    r_so <= r_slot;
                    if (slot_ok) begin
                        r_cs <= e_mode; r_bb <= 17'(e_fill); r_st <= ST_OK;
                        if (r_act == ACT_LISTEN) begin
                            r_cs <= MODE_LISTEN;
                        end else if (r_act == ACT_CONSUME) begin
                            if (e_fill >= FW'(r_rlen)) r_bb <= 17'(e_fill - FW'(r_rlen));
                            else r_st <= ST_NODATA;
                        end else if (e_mode == MODE_CWAIT || e_mode == MODE_CLOSED) begin
                            r_cs <= MODE_CLOSED; r_bb <= '0;
                        end else begin
                            r_st <= ST_FAIL;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_send_valid     = r_sv;
    assign o_reply_type     = r_rt;
    assign o_reply_src_port = r_rs;
    assign o_reply_dst_port = r_rd;
    assign o_reply_ack      = r_ra;
    assign o_status         = r_st;
    assign o_slot_out       = r_so;
    assign o_conn_state     = r_cs;
    assign o_buffered_bytes = r_bb;
endmodule
